// ===== rtl/core/pidaw_pkg.sv =====
// Shared types and constants for the PID controller with integral clamp.
// No dependencies; read first by the interfaces and the controller.
package pidaw_pkg;

   localparam int ERR_W       = 16;  // error sample, signed Q8.8
   localparam int DT_W        = 16;  // time step, unsigned Q4.12
   localparam int GAIN_W      = 16;  // gains, unsigned Q8.8
   localparam int LIMIT_W     = 31;  // integral bound, Q16.16 magnitude
   localparam int INTEG_W     = 32;  // integral accumulator, signed Q16.16
   localparam int DRIVE_W     = 32;  // drive, signed Q16.16
   localparam int CSR_DATA_W  = 31;  // widest register

   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 17;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int SUM_W       = 48;

   localparam int DIFF_W      = ERR_W + 1;
   localparam int DIV_FRAC    = 20;
   localparam int DIV_STEPS   = ERR_W + DIV_FRAC;
   localparam int COUNT_W     = $clog2(DIV_STEPS);
   localparam int DERIV_W     = DIV_STEPS + 1;
   localparam int DERIV_LO_W  = 16;

   typedef enum logic [1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_INT_LIMIT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_INC,
      ST_CLAMP,
      ST_MUL_I,
      ST_ADD_I,
      ST_DIV,
      ST_MUL_DH,
      ST_MUL_DL,
      ST_ADD_DL,
      ST_SAT
   } state_type;

endpackage

// ===== rtl/core/pidaw_if.sv =====
// Valid/ready channel interfaces for the PID controller: request and response.
// Depends on pidaw_pkg for field widths.
interface pidaw_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pidaw_pkg::ERR_W-1:0]  error_sample;
   logic        [pidaw_pkg::DT_W-1:0]   time_step;

   modport source (output valid, error_sample, time_step, input ready);
   modport sink   (input valid, error_sample, time_step, output ready);
endinterface

interface pidaw_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pidaw_pkg::DRIVE_W-1:0]  drive_value;

   modport source (output valid, drive_value, input ready);
   modport sink   (input valid, drive_value, output ready);
endinterface

// ===== rtl/core/pid_antiwindup_controller.sv =====
// PID controller with integral clamp: iterative datapath around one 33x17 multiplier
// and a radix-2 restoring divider. Depends on pidaw_pkg, pidaw_req_if and pidaw_rsp_if.
// Requests are taken only in the idle state: a new sample waits until the last one has
// passed the saturate step. Each sample runs the 36-step divider for the derivative
// plus five passes through the shared multiplier and the clamp and saturate steps.
// Reset (synchronous, active high) zeroes gains, limit, integral, last error and rsp.valid.
module pid_antiwindup_controller (
   input  logic                               clock,
   input  logic                               reset,
   pidaw_req_if.sink                          req,
   pidaw_rsp_if.source                        rsp,
   input  logic                               csr_write_enable,
   input  pidaw_pkg::csr_index_type           csr_index,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import pidaw_pkg::*;

   state_type                   state_ff, state_in;

   logic        [GAIN_W-1:0]    gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [LIMIT_W-1:0]   limit_ff;
   logic signed [INTEG_W-1:0]   integral_ff, integral_in;
   logic signed [ERR_W-1:0]     last_error_ff;
   logic signed [ERR_W-1:0]     err_ff;
   logic        [DT_W-1:0]      dt_ff;

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;

   logic        [DT_W-1:0]      rem_ff, rem_in;
   logic        [DIV_STEPS-1:0] quot_ff, quot_in;
   logic        [DT_W-1:0]      divisor_ff, divisor_in;
   logic                        neg_ff, neg_in;
   logic        [COUNT_W-1:0]   count_ff, count_in;

   logic signed [DRIVE_W-1:0]   drive_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        accept;
   logic                        sat_fire;

   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;

   logic signed [MUL_A_W-1:0]   inc;
   logic signed [INTEG_W+1:0]   acc_sum;
   logic signed [INTEG_W+1:0]   lim_ext;
   logic signed [INTEG_W+1:0]   clamped;

   logic signed [DIFF_W-1:0]    diff;
   logic signed [DIFF_W-1:0]    diff_abs;
   logic signed [DERIV_W-1:0]   deriv;

   logic        [DT_W:0]        rem_sh;
   logic        [DT_W:0]        rem_sub;
   logic                        quot_bit;

   logic signed [DRIVE_W-1:0]   drive_sat;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req.valid) state_in = ST_MUL_P;
         ST_MUL_P:   state_in = ST_MUL_INC;
         ST_MUL_INC: state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_MUL_I;
         ST_MUL_I:   state_in = ST_ADD_I;
         ST_ADD_I:   state_in = ST_DIV;
         ST_DIV:     if (count_ff == '0) state_in = ST_MUL_DH;
         ST_MUL_DH:  state_in = ST_MUL_DL;
         ST_MUL_DL:  state_in = ST_ADD_DL;
         ST_ADD_DL:  state_in = ST_SAT;
         ST_SAT:     if (!(rsp_valid_ff && !rsp.ready)) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req.ready = 1'b0;
      sat_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req.ready = 1'b1;
         ST_SAT:  sat_fire  = !(rsp_valid_ff && !rsp.ready);
         default: ;
      endcase
   end

   assign accept = req.valid && req.ready;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_P: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = signed'({1'b0, gain_p_ff});
         end
         ST_MUL_INC: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = signed'({1'b0, dt_ff});
         end
         ST_MUL_I: begin
            mul_a = MUL_A_W'(integral_ff);
            mul_b = signed'({1'b0, gain_i_ff});
         end
         ST_MUL_DH: begin
            mul_a = MUL_A_W'(signed'(deriv[DERIV_W-1:DERIV_LO_W]));
            mul_b = signed'({1'b0, gain_d_ff});
         end
         ST_MUL_DL: begin
            mul_a = signed'({{(MUL_A_W-DERIV_LO_W){1'b0}}, deriv[DERIV_LO_W-1:0]});
            mul_b = signed'({1'b0, gain_d_ff});
         end
         default: ;
      endcase
   end

   // integral update with clamp; cleared on zero error
   always_comb begin
      inc     = signed'(prod_ff[MUL_A_W+3:4]);
      acc_sum = (INTEG_W+2)'(integral_ff) + (INTEG_W+2)'(inc);
      lim_ext = signed'({3'b000, limit_ff});
      if (err_ff == '0)
         clamped = '0;
      else if (acc_sum > lim_ext)
         clamped = lim_ext;
      else if (acc_sum < -lim_ext)
         clamped = -lim_ext;
      else
         clamped = acc_sum;
      integral_in = (state_ff == ST_CLAMP) ? clamped[INTEG_W-1:0] : integral_ff;
   end

   // derivative operands and divider step
   always_comb begin
      diff     = DIFF_W'(err_ff) - DIFF_W'(last_error_ff);
      diff_abs = diff[DIFF_W-1] ? -diff : diff;
      deriv    = neg_ff ? -signed'({1'b0, quot_ff}) : signed'({1'b0, quot_ff});
      rem_sh   = {rem_ff, quot_ff[DIV_STEPS-1]};
      rem_sub  = rem_sh - {1'b0, divisor_ff};
      quot_bit = rem_sh >= {1'b0, divisor_ff};
   end

   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      case (state_ff)
         ST_MUL_INC: sum_in = signed'(prod_ff[SUM_W-1:0]);
         ST_ADD_I: begin
            sum_in     = sum_ff + SUM_W'(prod_ff >>> 8);
            rem_in     = '0;
            quot_in    = {diff_abs[ERR_W-1:0], {DIV_FRAC{1'b0}}};
            neg_in     = diff[DIFF_W-1];
            divisor_in = (dt_ff == '0) ? DT_W'(1) : dt_ff;
            count_in   = COUNT_W'(DIV_STEPS - 1);
         end
         ST_DIV: begin
            rem_in   = quot_bit ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
            quot_in  = {quot_ff[DIV_STEPS-2:0], quot_bit};
            count_in = count_ff - COUNT_W'(1);
         end
         ST_MUL_DL: sum_in = sum_ff + SUM_W'(prod_ff <<< 8);
         ST_ADD_DL: sum_in = sum_ff + SUM_W'(prod_ff >>> 8);
         default: ;
      endcase
   end

   // saturate to signed 32 bits
   always_comb begin
      if (!sum_ff[SUM_W-1] && (sum_ff[SUM_W-2:DRIVE_W-1] != '0))
         drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
      else if (sum_ff[SUM_W-1] && (sum_ff[SUM_W-2:DRIVE_W-1] != '1))
         drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
      else
         drive_sat = sum_ff[DRIVE_W-1:0];
   end

   assign rsp_valid_in    = (rsp_valid_ff && !rsp.ready) || sat_fire;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drive_value = drive_ff;

   // control state and stored controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_ff      <= '0;
         integral_ff   <= '0;
         last_error_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         if (sat_fire) last_error_ff <= err_ff;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_GAIN_P:    gain_p_ff <= csr_write_data[GAIN_W-1:0];
               CSR_GAIN_I:    gain_i_ff <= csr_write_data[GAIN_W-1:0];
               CSR_GAIN_D:    gain_d_ff <= csr_write_data[GAIN_W-1:0];
               CSR_INT_LIMIT: limit_ff  <= csr_write_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff    <= mul_a * mul_b;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      count_ff   <= count_in;
      if (accept) begin
         err_ff <= req.error_sample;
         dt_ff  <= req.time_step;
      end
      if (sat_fire) drive_ff <= drive_sat;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL_P)
      else $error("sequencer did not start after request transfer");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   a_integral_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLAMP |=>
         (33'(integral_ff) <= signed'({2'b00, limit_ff})) &&
         (33'(integral_ff) >= -signed'({2'b00, limit_ff})))
      else $error("integral outside limit after clamp");

   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      sat_fire |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not presented after saturation step");
`endif

endmodule

// ===== verif/pid_antiwindup_controller_tb.sv =====
`timescale 1ns / 1ps
// Testbench for pid_antiwindup_controller: directed table then paced random traffic,
// each drive value checked against a fixed table value or an in-bench fixed-point PID model.
// Depends on pidaw_pkg, pidaw_req_if and pidaw_rsp_if from the RTL.
module pid_antiwindup_controller_tb;
   import pidaw_pkg::*;

   typedef struct {
      bit                 is_write;
      csr_index_type      idx;
      logic [30:0]        wdata;
      logic signed [15:0] err;
      logic [15:0]        dt;
      bit                 fixed;
      logic signed [31:0] drive;
   } pid_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pidaw_req_if req_ch ();
   pidaw_rsp_if rsp_ch ();

   // model copy of registers and state
   longint kp, ki, kd, int_limit;
   int integ_state;
   logic signed [15:0] prev_error;

   logic signed [31:0] pending_drives[$];
   logic signed [31:0] drive_want;
   pid_row_type pid_rows[$];
   int mismatch_count = 0;
   int drives_checked = 0;
   int samples_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   pid_antiwindup_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [31:0] compute_drive(input logic signed [15:0] e,
                                                        input logic [15:0] d);
      longint err, dt, lim, p, acc, i_term, d_term, deriv, divisor, sum;
      logic [63:0] bits;
      err = e;
      dt = {48'd0, d};
      lim = int_limit;
      p = err * kp;
      acc = longint'(integ_state) + ((err * dt) >>> 4);
      if (acc > lim)
         acc = lim;
      else if (acc < -lim)
         acc = -lim;
      if (err == 0)
         acc = 0;
      bits = acc;
      integ_state = bits[31:0];
      i_term = (acc * ki) >>> 8;
      divisor = (dt == 0) ? 64'sd1 : dt;
      deriv = ((err - longint'(prev_error)) * 64'sd1048576) / divisor;
      d_term = (deriv * kd) >>> 8;
      prev_error = e;
      sum = p + i_term + d_term;
      if (sum > 64'sd2147483647)
         sum = 64'sd2147483647;
      else if (sum < -64'sd2147483648)
         sum = -64'sd2147483648;
      bits = sum;
      return bits[31:0];
   endfunction

   task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
      $display("[%0t] mismatch: %s: expected %0d got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic add_write(input csr_index_type idx, input logic [30:0] data);
      pid_row_type r;
      r = '{1'b1, idx, data, 16'sd0, 16'd0, 1'b0, 32'sd0};
      pid_rows.push_back(r);
   endtask

   task automatic add_sample(input logic signed [15:0] e, input logic [15:0] d,
                             input bit fixed, input logic signed [31:0] val);
      pid_row_type r;
      r = '{1'b0, CSR_GAIN_P, 31'd0, e, d, fixed, val};
      pid_rows.push_back(r);
   endtask

   task automatic send_sample(input logic signed [15:0] e, input logic [15:0] d,
                              input bit fixed, input logic signed [31:0] val);
      logic signed [31:0] predicted;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.error_sample <= e;
      req_ch.time_step <= d;
      do @(posedge clock); while (!req_ch.ready);
      predicted = compute_drive(e, d);
      pending_drives.push_back(fixed ? val : predicted);
      samples_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [30:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_GAIN_P:    kp = {48'd0, data[15:0]};
         CSR_GAIN_I:    ki = {48'd0, data[15:0]};
         CSR_GAIN_D:    kd = {48'd0, data[15:0]};
         CSR_INT_LIMIT: int_limit = {33'd0, data};
         default: ;
      endcase
   endtask

   function automatic logic [30:0] pick_csr_value(input bit is_limit);
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(3))
         0: return 31'd0;
         1: return is_limit ? 31'h7fffffff : 31'h0000ffff;
         2: return is_limit ? {7'd0, r[23:0]} : {21'd0, r[9:0]};
         default: return r[30:0];
      endcase
   endfunction

   function automatic logic signed [15:0] random_error();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3, 4: return {{7{r[8]}}, r[8:0]};
         default: return r[15:0];
      endcase
   endfunction

   function automatic logic [15:0] random_step();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(39))
         0: return 16'd0;
         1, 2: return 16'd1;
         3, 4: return 16'hffff;
         5, 6, 7, 8, 9, 10, 11, 12: return {4'd0, r[11:0]};
         default: return r[15:0];
      endcase
   endfunction

   task automatic set_pacing(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
         default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
   endtask

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_drives.size() == 0) begin
            report_mismatch("transfer with nothing pending", 32'sd0, rsp_ch.drive_value);
         end else begin
            drive_want = pending_drives.pop_front();
            drives_checked++;
            if (rsp_ch.drive_value !== drive_want)
               report_mismatch("drive_value", drive_want, rsp_ch.drive_value);
         end
      end
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int chunk;
      int n;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_GAIN_P;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.error_sample = '0;
      req_ch.time_step = '0;
      rsp_ch.ready = 1'b0;
      kp = 0; ki = 0; kd = 0; int_limit = 0;
      integ_state = 0;
      prev_error = '0;

      // gains zero after reset
      add_sample(16'sh7fff, 16'hffff, 1'b1, 32'sd0);
      add_sample(16'sh8000, 16'h0001, 1'b1, 32'sd0);
      add_sample(16'sh0000, 16'h0000, 1'b1, 32'sd0);
      // unity proportional only
      add_write(CSR_GAIN_P, 31'h0000_0100);
      add_sample(16'sh7fff, 16'h0001, 1'b1, 32'sh007fff00);
      add_sample(16'sh8000, 16'h0001, 1'b1, 32'shff800000);
      // full proportional and derivative gains, saturation both ways
      add_write(CSR_GAIN_P, 31'h0000_ffff);
      add_write(CSR_GAIN_D, 31'h0000_ffff);
      add_sample(16'sh8000, 16'h0001, 1'b1, 32'sh80008000);
      add_sample(16'sh7fff, 16'h0001, 1'b1, 32'sh7fffffff);
      add_sample(16'sh8000, 16'h0001, 1'b1, 32'sh80000000);
      // integral wind-up against the widest limit
      add_write(CSR_GAIN_P, 31'h0000_0040);
      add_write(CSR_GAIN_I, 31'h0000_0200);
      add_write(CSR_GAIN_D, 31'h0000_0010);
      add_write(CSR_INT_LIMIT, 31'h7fff_ffff);
      add_sample(16'sh7fff, 16'hffff, 1'b0, 32'sd0);
      add_sample(16'sh7fff, 16'hffff, 1'b0, 32'sd0);
      add_sample(16'sh7fff, 16'hffff, 1'b0, 32'sd0);
      add_sample(16'sh0123, 16'h0000, 1'b0, 32'sd0);
      // limit dropped below the stored integral
      add_write(CSR_INT_LIMIT, 31'h0001_0000);
      add_sample(16'sh0100, 16'h1000, 1'b0, 32'sd0);
      add_sample(16'sh0000, 16'h1000, 1'b0, 32'sd0);
      add_sample(16'shff00, 16'h1000, 1'b0, 32'sd0);
      add_write(CSR_INT_LIMIT, 31'h0000_0000);
      add_sample(16'sh4000, 16'h0800, 1'b0, 32'sd0);
      // negative wind-up, upper data bits masked off the gain
      add_write(CSR_GAIN_I, 31'h7fff_ffff);
      add_write(CSR_INT_LIMIT, 31'h7fff_ffff);
      add_sample(16'sh8000, 16'hffff, 1'b0, 32'sd0);
      add_sample(16'sh8000, 16'hffff, 1'b0, 32'sd0);
      add_sample(16'sh8000, 16'hffff, 1'b0, 32'sd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_pacing(0);
      foreach (pid_rows[i]) begin
         if (pid_rows[i].is_write) begin
            drain_results();
            write_csr(pid_rows[i].idx, pid_rows[i].wdata);
         end else begin
            send_sample(pid_rows[i].err, pid_rows[i].dt, pid_rows[i].fixed,
                        pid_rows[i].drive);
         end
      end

      for (chunk = 0; chunk < 8; chunk++) begin
         drain_results();
         set_pacing(chunk % 4);
         if (chunk == 0) begin
            write_csr(CSR_GAIN_P, 31'h7fffffff);
            write_csr(CSR_GAIN_I, 31'h7fffffff);
            write_csr(CSR_GAIN_D, 31'h7fffffff);
            write_csr(CSR_INT_LIMIT, 31'h7fffffff);
         end else if (chunk == 1) begin
            write_csr(CSR_GAIN_P, 31'd0);
            write_csr(CSR_GAIN_I, 31'd0);
            write_csr(CSR_GAIN_D, 31'd0);
            write_csr(CSR_INT_LIMIT, 31'd0);
         end else begin
            write_csr(CSR_GAIN_P, pick_csr_value(1'b0));
            write_csr(CSR_GAIN_I, pick_csr_value(1'b0));
            write_csr(CSR_GAIN_D, pick_csr_value(1'b0));
            write_csr(CSR_INT_LIMIT, pick_csr_value(1'b1));
         end
         for (n = 0; n < 85; n++) begin
            if (chunk == 3 && n == 40)
               drain_results();
            send_sample(random_error(), random_step(), 1'b0, 32'sd0);
         end
      end

      drain_results();
      repeat (50) @(posedge clock);
      $display("summary: %0d samples sent, %0d drive values checked", samples_sent,
               drives_checked);
      $display("summary: directed table plus 8 paced random phases, gains and limit 0 to max");
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== pid_antiwindup_controller.f =====
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_if.sv
rtl/core/pid_antiwindup_controller.sv
verif/pid_antiwindup_controller_tb.sv
